// ===== rtl/fcs_pkg.sv =====
`timescale 1ns / 1ps

package fcs_pkg;

  // Field widths
  localparam int OFS_W  = 16;
  localparam int ADDR_W = 24;
  localparam int BYTE_W = 8;

  // Bank register width (1..8)
  localparam int BANK_BITS = 8;

  // Config port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_FLASH_PRESENT = 2'd0;
  localparam logic [1:0] REG_MANUFACTURER  = 2'd1;
  localparam logic [1:0] REG_DEVICE        = 2'd2;

  // Unlock addresses within the save window
  localparam logic [OFS_W-1:0] ADR_A = 16'h5555;
  localparam logic [OFS_W-1:0] ADR_B = 16'h2AAA;

  // Bus bytes
  localparam logic [BYTE_W-1:0] BYTE_UNLOCK1 = 8'hAA;
  localparam logic [BYTE_W-1:0] BYTE_UNLOCK2 = 8'h55;
  localparam logic [BYTE_W-1:0] CMD_NONE     = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_ERASE    = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_CHIP_ID  = 8'h90;
  localparam logic [BYTE_W-1:0] CMD_PROGRAM  = 8'hA0;
  localparam logic [BYTE_W-1:0] CMD_BANK     = 8'hB0;
  localparam logic [BYTE_W-1:0] CMD_RESET    = 8'hF0;
  localparam logic [BYTE_W-1:0] CMD_SECTOR   = 8'h30;
  localparam logic [BYTE_W-1:0] BYTE_BLANK   = 8'hFF;

  localparam int SECTOR_BITS = 12;  // 4 KiB sectors

  typedef enum logic [3:0] {
    ST_IDLE = 4'd0,
    ST_UNL1 = 4'd1,
    ST_UNL2 = 4'd2,
    ST_ER0  = 4'd3,
    ST_ER1  = 4'd4,
    ST_ER2  = 4'd5,
    ST_ID0  = 4'd6,
    ST_ID1  = 4'd7,
    ST_ID2  = 4'd8
  } seq_state_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_DIRECT  = 3'd1,
    ACT_READ    = 3'd2,
    ACT_PROGRAM = 3'd3,
    ACT_ERASE   = 3'd4
  } action_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic              flash_present;
    logic [BYTE_W-1:0] manufacturer_id;
    logic [BYTE_W-1:0] device_id;
  } cfg_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [OFS_W-1:0]  offset;
    logic [BYTE_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    action_t           action;
    logic [ADDR_W-1:0] array_addr;
    logic [BYTE_W-1:0] program_data;
    logic [BYTE_W-1:0] read_value;
  } result_t;

endpackage

// ===== rtl/fcs_cfg_regs.sv =====
`timescale 1ns / 1ps

module fcs_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fcs_pkg::CFG_AW-1:0] paddr,
  input  logic [fcs_pkg::CFG_DW-1:0] pwdata,
  output logic [fcs_pkg::CFG_DW-1:0] prdata,
  output fcs_pkg::cfg_t              cfg
);
  import fcs_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_FLASH_PRESENT: cfg_nxt.flash_present   = pwdata[0];
        REG_MANUFACTURER:  cfg_nxt.manufacturer_id = pwdata[BYTE_W-1:0];
        REG_DEVICE:        cfg_nxt.device_id       = pwdata[BYTE_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flash_present   <= 1'b1;
      cfg_r.manufacturer_id <= 8'd50;
      cfg_r.device_id       <= 8'd27;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FLASH_PRESENT: prdata = CFG_DW'(cfg_r.flash_present);
      REG_MANUFACTURER:  prdata = CFG_DW'(cfg_r.manufacturer_id);
      REG_DEVICE:        prdata = CFG_DW'(cfg_r.device_id);
      default:           prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/fcs_core.sv =====
`timescale 1ns / 1ps

module fcs_core (
  input  logic              clk,
  input  logic              rst_n,
  input  fcs_pkg::cfg_t     cfg,
  input  logic              fire,
  input  fcs_pkg::item_t    item,
  output fcs_pkg::result_t  res
);
  import fcs_pkg::*;

  seq_state_t           seq_state_r, seq_state_nxt;
  logic [BYTE_W-1:0]    pending_r, pending_nxt;
  logic [BANK_BITS-1:0] bank_r, bank_nxt;
  logic                 broken;
  logic [ADDR_W-1:0]    bank_base;
  logic [OFS_W-1:0]     ofs;
  logic [BYTE_W-1:0]    val;

  assign ofs       = item.offset;
  assign val       = item.write_data;
  assign bank_base = {BYTE_W'(bank_r), {OFS_W{1'b0}}};

  always_comb begin
    seq_state_nxt = seq_state_r;
    pending_nxt   = pending_r;
    bank_nxt      = bank_r;
    broken        = 1'b0;
    res           = '0;
    res.action    = ACT_NONE;

    if (!cfg.flash_present) begin
      if (item.opcode == OP_READ) begin
        res.action     = ACT_DIRECT;
        res.read_value = BYTE_BLANK;
      end
    end else if (item.opcode == OP_READ) begin
      if (pending_r == CMD_NONE) begin
        res.action     = ACT_READ;
        res.array_addr = bank_base + ADDR_W'(ofs);
      end else begin
        res.action     = ACT_DIRECT;
        res.read_value = BYTE_BLANK;
        if (pending_r == CMD_CHIP_ID && ofs == 16'd0) begin
          res.read_value = cfg.manufacturer_id;
        end else if (pending_r == CMD_CHIP_ID && ofs == 16'd1) begin
          res.read_value = cfg.device_id;
        end else if (pending_r == CMD_RESET) begin
          seq_state_nxt = ST_IDLE;
          pending_nxt   = CMD_NONE;
        end
      end
    end else begin
      case (seq_state_r)
        ST_UNL1: begin
          if (ofs == ADR_B && val == BYTE_UNLOCK2) begin
            seq_state_nxt = ST_UNL2;
          end else begin
            seq_state_nxt = ST_IDLE;
            broken        = 1'b1;
          end
        end
        ST_UNL2: begin
          if (ofs == ADR_A) begin
            pending_nxt = val;
            if (val == CMD_ERASE) seq_state_nxt = ST_ER0;
            else if (val == CMD_CHIP_ID) seq_state_nxt = ST_ID0;
            else seq_state_nxt = ST_IDLE;
          end else begin
            seq_state_nxt = ST_IDLE;
            broken        = 1'b1;
          end
        end
        ST_ER0, ST_ID0: begin
          if (ofs == ADR_A && val == BYTE_UNLOCK1) begin
            seq_state_nxt = (seq_state_r == ST_ER0) ? ST_ER1 : ST_ID1;
          end else begin
            seq_state_nxt = ST_IDLE;
            broken        = 1'b1;
          end
        end
        ST_ER1, ST_ID1: begin
          if (ofs == ADR_B && val == BYTE_UNLOCK2) begin
            seq_state_nxt = (seq_state_r == ST_ER1) ? ST_ER2 : ST_ID2;
          end else begin
            seq_state_nxt = ST_IDLE;
            broken        = 1'b1;
          end
        end
        ST_ER2: begin
          seq_state_nxt = ST_IDLE;
          pending_nxt   = CMD_NONE;
          if (val == CMD_SECTOR) begin
            res.action     = ACT_ERASE;
            res.array_addr = bank_base +
                             ADDR_W'({ofs[OFS_W-1:SECTOR_BITS], {SECTOR_BITS{1'b0}}});
          end
        end
        ST_ID2: begin
          seq_state_nxt = ST_IDLE;
          pending_nxt   = CMD_NONE;
        end
        default: begin
          // idle, and any unused code behaves as idle
          seq_state_nxt = ST_IDLE;
          if (ofs == ADR_A && val == CMD_RESET) begin
            pending_nxt = CMD_NONE;
          end else if (ofs == ADR_A && val == BYTE_UNLOCK1) begin
            seq_state_nxt = ST_UNL1;
          end else if (ofs == 16'd0 && pending_r == CMD_BANK) begin
            bank_nxt    = val[BANK_BITS-1:0];
            pending_nxt = CMD_NONE;
          end else begin
            broken = 1'b1;
          end
        end
      endcase

      // stray write while byte program is armed: program it
      if (broken && pending_r == CMD_PROGRAM) begin
        seq_state_nxt    = ST_IDLE;
        pending_nxt      = CMD_NONE;
        res.action       = ACT_PROGRAM;
        res.array_addr   = bank_base + ADDR_W'(ofs);
        res.program_data = val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_state_r <= ST_IDLE;
      pending_r   <= CMD_NONE;
      bank_r      <= '0;
    end else if (fire) begin
      seq_state_r <= seq_state_nxt;
      pending_r   <= pending_nxt;
      bank_r      <= bank_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_absent_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !cfg.flash_present |=>
      $stable(seq_state_r) && $stable(pending_r) && $stable(bank_r))
    else $error("state changed while flash absent");

  a_erase_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.action == ACT_ERASE |=> seq_state_r == ST_IDLE && pending_r == CMD_NONE)
    else $error("erase did not end the command");

  a_erase_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    res.action == ACT_ERASE |-> res.array_addr[SECTOR_BITS-1:0] == '0)
    else $error("erase address not sector aligned");

  a_program_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.action == ACT_PROGRAM |=> pending_r == CMD_NONE)
    else $error("program command still pending");
`endif

endmodule

// ===== rtl/flash_command_sequencer_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake                 Payload
// in_       in   in_tvalid / in_tready     tuser: opcode; tdata: offset, write_data
// out_      out  out_tvalid / out_tready   tuser: action; tdata: addr, prog, read
// cfg_      in   APB psel/penable/pready   flash_present @0, manufacturer_id @4,
//                                          device_id @8
//
// Every transaction passes the input register, then the result register, from
// acceptance to result. One transaction per cycle is sustained with out_tready
// high; the sequencer state update in fcs_core is the feedback loop.
// Synchronous active-low reset: sequencer idle, no command, bank 0, flash
// present, ID bytes 50 / 27. A stalled result holds the result register; the
// input register still accepts until it is full too.

module flash_command_sequencer_unit (
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // [15:0] offset, [23:16] write_data
  input  logic                       in_tuser,   // [0] opcode

  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [39:0]                out_tdata,  // [23:0] array_addr,
                                                 // [31:24] program_data,
                                                 // [39:32] read_value
  output logic [2:0]                 out_tuser,  // [2:0] action

  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [fcs_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [fcs_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [fcs_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import fcs_pkg::*;

  cfg_t    cfg;
  item_t   stg_item_r, stg_item_nxt;
  logic    stg_valid_r, stg_valid_nxt;
  result_t out_res_r;
  result_t core_res;
  logic    out_valid_r, out_valid_nxt;
  logic    out_load;   // result register free this cycle
  logic    fire;       // staged transaction moves to the result register

  assign cfg_pready = 1'b1;

  fcs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign out_load  = !out_valid_r || out_tready;
  assign fire      = stg_valid_r && out_load;
  assign in_tready = !stg_valid_r || out_load;

  always_comb begin
    stg_item_nxt = stg_item_r;
    if (in_tvalid && in_tready) begin
      stg_item_nxt.opcode     = opcode_t'(in_tuser);
      stg_item_nxt.offset     = in_tdata[OFS_W-1:0];
      stg_item_nxt.write_data = in_tdata[OFS_W+BYTE_W-1:OFS_W];
    end
    stg_valid_nxt = in_tready ? in_tvalid : stg_valid_r;
    out_valid_nxt = out_load ? stg_valid_r : out_valid_r;
  end

  fcs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .item  (stg_item_r),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    stg_item_r <= stg_item_nxt;
    if (fire) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.action;
  assign out_tdata  = {out_res_r.read_value, out_res_r.program_data, out_res_r.array_addr};

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> stg_valid_r && out_valid_r && !out_tready)
    else $error("input stalled while pipeline has room");

  a_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("staged transaction lost");

  a_direct_only_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ACT_DIRECT |-> out_res_r.read_value == '0)
    else $error("read value set on non-direct result");
`endif

endmodule
